FILE: rtl/glzw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_pkg
// shared types and constants of the lzw code decoder
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int PIXEL_BITS_DEF    = 8;
    localparam int BUF_BITS          = 24;
    localparam int CNT_BITS          = 5;
    localparam int CW_BITS           = 4;
    localparam int REG_MIN_CODE_SIZE = 0;
    localparam logic [3:0] MIN_CODE_SIZE_RST = 4'd8;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic       index_valid;
        logic [7:0] pixel_index;
        logic       code_done;
        logic       byte_taken;
        logic       end_code_seen;
        logic       ended_early;
        logic       bad_code;
    } out_item_t;

endpackage

FILE: rtl/glzw_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_tables
// dictionary and expansion stack memories, registered (synchronous) reads
// ----------------------------------------------------------------------------
module glzw_tables #(
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int PIXEL_BITS    = glzw_pkg::PIXEL_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     dict_we,
    input  logic [MAX_CODE_BITS-1:0] dict_waddr,
    input  logic [MAX_CODE_BITS-1:0] dict_wprefix,
    input  logic [PIXEL_BITS-1:0]    dict_wsuffix,
    input  logic [PIXEL_BITS-1:0]    dict_wfirst,
    input  logic [MAX_CODE_BITS-1:0] dict_raddr,
    output logic [MAX_CODE_BITS-1:0] dict_rprefix,
    output logic [PIXEL_BITS-1:0]    dict_rsuffix,
    output logic [PIXEL_BITS-1:0]    dict_rfirst,
    input  logic                     stk_we,
    input  logic [MAX_CODE_BITS-1:0] stk_waddr,
    input  logic [PIXEL_BITS-1:0]    stk_wdata,
    input  logic [MAX_CODE_BITS-1:0] stk_raddr,
    output logic [PIXEL_BITS-1:0]    stk_rdata
);
    import glzw_pkg::*;

    localparam int DEPTH = 1 << MAX_CODE_BITS;

    logic [MAX_CODE_BITS-1:0] prefix_mem [DEPTH];
    logic [PIXEL_BITS-1:0]    suffix_mem [DEPTH];
    logic [PIXEL_BITS-1:0]    first_mem  [DEPTH];
    logic [PIXEL_BITS-1:0]    stack_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            prefix_mem[dict_waddr] <= dict_wprefix;
            suffix_mem[dict_waddr] <= dict_wsuffix;
            first_mem[dict_waddr]  <= dict_wfirst;
        end
        dict_rprefix <= prefix_mem[dict_raddr];
        dict_rsuffix <= suffix_mem[dict_raddr];
        dict_rfirst  <= first_mem[dict_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        stk_rdata <= stack_mem[stk_raddr];
    end

endmodule

FILE: rtl/glzw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_ctrl
// bit unpacking, code decode, chain walk and stack pop sequencer
// ----------------------------------------------------------------------------
module glzw_ctrl #(
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int PIXEL_BITS    = glzw_pkg::PIXEL_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     restart,
    input  logic [3:0]               min_code_size,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  glzw_pkg::in_item_t       in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output glzw_pkg::out_item_t      out_data,
    output logic                     dict_we,
    output logic [MAX_CODE_BITS-1:0] dict_waddr,
    output logic [MAX_CODE_BITS-1:0] dict_wprefix,
    output logic [PIXEL_BITS-1:0]    dict_wsuffix,
    output logic [PIXEL_BITS-1:0]    dict_wfirst,
    output logic [MAX_CODE_BITS-1:0] dict_raddr,
    input  logic [MAX_CODE_BITS-1:0] dict_rprefix,
    input  logic [PIXEL_BITS-1:0]    dict_rsuffix,
    input  logic [PIXEL_BITS-1:0]    dict_rfirst,
    output logic                     stk_we,
    output logic [MAX_CODE_BITS-1:0] stk_waddr,
    output logic [PIXEL_BITS-1:0]    stk_wdata,
    output logic [MAX_CODE_BITS-1:0] stk_raddr,
    input  logic [PIXEL_BITS-1:0]    stk_rdata
);
    import glzw_pkg::*;

    localparam int MC = MAX_CODE_BITS;
    localparam int NF = MAX_CODE_BITS + 1;
    localparam logic [NF-1:0] FULL = NF'(1) << MAX_CODE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DLOOK, ST_WALK, ST_WREAD, ST_EMIT, ST_EREAD, ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [BUF_BITS-1:0]   buf_reg, buf_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [CW_BITS-1:0]    cw_reg, cw_next;
    logic [NF-1:0]         nfc_reg, nfc_next;
    logic [MC-1:0]         prev_reg, prev_next;
    logic [PIXEL_BITS-1:0] pfirst_reg, pfirst_next;
    logic                  havep_reg, havep_next;
    logic [MC-1:0]         walk_reg, walk_next;
    logic [NF-1:0]         sp_reg, sp_next;
    logic                  ftaken_reg, ftaken_next;
    logic                  end_reg, end_next;
    logic                  bad_reg, bad_next;
    logic [MC-1:0]         code_reg, code_next;
    logic                  ov_reg, ov_next;
    out_item_t             od_reg, od_next;

    logic [NF-1:0]         clr;
    logic [MC-1:0]         code_w;
    logic                  go;
    logic                  step;

    assign clr      = NF'(1) << min_code_size;
    assign code_w   = MC'(buf_reg & ((BUF_BITS'(1) << cw_reg) - BUF_BITS'(1)));
    assign go       = !ov_reg || out_ready;
    assign in_ready = go && !restart && (state_reg != ST_DLOOK) && (state_reg != ST_WREAD)
                      && (state_reg != ST_EREAD);
    assign step     = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        logic [NF-1:0]         nf1;
        logic [PIXEL_BITS-1:0] fst;
        logic                  add;
        logic [NF-1:0]         ccode;
        state_next  = state_reg;
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        cw_next     = cw_reg;
        nfc_next    = nfc_reg;
        prev_next   = prev_reg;
        pfirst_next = pfirst_reg;
        havep_next  = havep_reg;
        walk_next   = walk_reg;
        sp_next     = sp_reg;
        ftaken_next = ftaken_reg;
        end_next    = end_reg;
        bad_next    = bad_reg;
        code_next   = code_reg;
        ov_next     = ov_reg && !out_ready;
        od_next     = od_reg;
        dict_we     = 1'b0;
        dict_waddr  = nfc_reg[MC-1:0];
        dict_wprefix = prev_reg;
        dict_wsuffix = pfirst_reg;
        dict_wfirst  = pfirst_reg;
        dict_raddr  = walk_reg;
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[MC-1:0];
        stk_wdata   = '0;
        stk_raddr   = MC'(sp_reg - NF'(1));
        nf1 = '0;
        fst = '0;
        add = 1'b0;
        ccode = NF'(code_reg);

        // internal cycles between ticks: memory reads settle
        case (state_reg)
            ST_DLOOK:
            begin
                // first index of an existing code now read
                fst = (ccode < clr) ? PIXEL_BITS'(code_reg) : dict_rfirst;
                if (havep_reg && nfc_reg < FULL)
                begin
                    dict_we = 1'b1;
                    dict_wsuffix = fst;
                    add = 1'b1;
                end
                walk_next   = code_reg;
                prev_next   = code_reg;
                pfirst_next = fst;
                havep_next  = 1'b1;
                state_next  = ST_WALK;
            end
            ST_WREAD:
            begin
                stk_we    = 1'b1;
                stk_wdata = dict_rsuffix;
                sp_next   = sp_reg + NF'(1);
                walk_next = dict_rprefix;
                state_next = ST_WALK;
            end
            ST_EREAD:
            begin
                state_next = ST_EMIT;
            end
            default:
            begin
            end
        endcase

        if (step)
        begin
            ov_next = 1'b1;
            od_next = '0;
            case (state_reg)
                ST_WALK:
                begin
                    if (NF'(walk_reg) < clr)
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = PIXEL_BITS'(walk_reg);
                        sp_next   = sp_reg + NF'(1);
                        state_next = ST_EREAD;
                    end
                    else
                    begin
                        dict_raddr = walk_reg;
                        state_next = ST_WREAD;
                    end
                end
                ST_EMIT:
                begin
                    od_next.index_valid = 1'b1;
                    od_next.pixel_index = stk_rdata;
                    sp_next = sp_reg - NF'(1);
                    stk_raddr = MC'(sp_reg - NF'(2));
                    if (sp_reg == NF'(1))
                    begin
                        od_next.code_done = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_EREAD;
                end
                ST_IDLE:
                begin
                    if ({1'b0, cnt_reg} >= {2'b0, cw_reg})
                    begin
                        buf_next = buf_reg >> cw_reg;
                        cnt_next = cnt_reg - CNT_BITS'(cw_reg);
                        ccode = NF'(code_w);
                        code_next = code_w;
                        if (ccode == clr)
                        begin
                            cw_next  = CW_BITS'(min_code_size + 4'd1);
                            nfc_next = clr + NF'(2);
                            havep_next = 1'b0;
                        end
                        else if (ccode == clr + NF'(1))
                        begin
                            end_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        else if (ccode > nfc_reg || (ccode == nfc_reg && !havep_reg))
                            bad_next = 1'b1;
                        else if (ccode == nfc_reg)
                        begin
                            if (nfc_reg < FULL)
                            begin
                                dict_we = 1'b1;
                                add = 1'b1;
                            end
                            stk_we    = 1'b1;
                            stk_wdata = pfirst_reg;
                            sp_next   = sp_reg + NF'(1);
                            walk_next = prev_reg;
                            prev_next = code_w;
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            dict_raddr = code_w;
                            state_next = ST_DLOOK;
                        end
                    end
                    else if (ftaken_reg)
                        state_next = ST_DONE;
                    else if (in_data.byte_valid)
                    begin
                        buf_next = buf_reg | (BUF_BITS'(in_data.data_byte) << cnt_reg);
                        cnt_next = cnt_reg + CNT_BITS'(8);
                        od_next.byte_taken = 1'b1;
                        if (in_data.final_byte)
                            ftaken_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            od_next.end_code_seen = end_next;
            od_next.ended_early   = (state_next == ST_DONE) && !end_next;
            od_next.bad_code      = bad_next;
        end

        if (add)
        begin
            nf1 = nfc_reg + NF'(1);
            nfc_next = nf1;
            if (cw_reg < CW_BITS'(MAX_CODE_BITS) && nf1 == (NF'(1) << cw_reg))
                cw_next = cw_reg + CW_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            buf_reg    <= '0;
            cnt_reg    <= '0;
            cw_reg     <= CW_BITS'(MIN_CODE_SIZE_RST + 4'd1);
            nfc_reg    <= (NF'(1) << MIN_CODE_SIZE_RST) + NF'(2);
            prev_reg   <= '0;
            pfirst_reg <= '0;
            havep_reg  <= 1'b0;
            walk_reg   <= '0;
            sp_reg     <= '0;
            ftaken_reg <= 1'b0;
            end_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else if (restart)
        begin
            state_reg  <= ST_IDLE;
            buf_reg    <= '0;
            cnt_reg    <= '0;
            cw_reg     <= CW_BITS'(min_code_size + 4'd1);
            nfc_reg    <= clr + NF'(2);
            prev_reg   <= '0;
            pfirst_reg <= '0;
            havep_reg  <= 1'b0;
            walk_reg   <= '0;
            sp_reg     <= '0;
            ftaken_reg <= 1'b0;
            end_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            ov_reg     <= ov_next;
        end
        else
        begin
            state_reg  <= state_next;
            buf_reg    <= buf_next;
            cnt_reg    <= cnt_next;
            cw_reg     <= cw_next;
            nfc_reg    <= nfc_next;
            prev_reg   <= prev_next;
            pfirst_reg <= pfirst_next;
            havep_reg  <= havep_next;
            walk_reg   <= walk_next;
            sp_reg     <= sp_next;
            ftaken_reg <= ftaken_next;
            end_reg    <= end_next;
            bad_reg    <= bad_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        od_reg   <= od_next;
    end

endmodule

FILE: rtl/gif_lzw_code_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_code_decoder_top
// gif style variable width lzw decoder, one tick item per result item
// ----------------------------------------------------------------------------
// in channel: one tick per transfer, optionally carrying a compressed byte
// out channel: one result per tick, held in an output register; the next tick
//   is taken while that result waits, as long as the register frees in time
// each tick does at most one step: take a byte, decode a code, push one chain link,
//   or pop one pixel index
// ticks that decode a literal or an existing dictionary code, push a chain
//   link, or pop an index other than the last of a string are followed by an
//   internal read state (DLOOK, WREAD or EREAD) that holds off ticks; the
//   synchronous dictionary and stack memories (one read port each) need it
// each result is registered and is valid in the cycle after its tick transfer
// when the receiver stalls, ticks are held off once the output register is full
// reset or a min_code_size write restarts decoding; memories need no clearing
// the cycle after a min_code_size write holds off ticks while decoding restarts
// apb: min_code_size at address 0, read back as stored (clamped 2..PIXEL_BITS)
// ----------------------------------------------------------------------------
module gif_lzw_code_decoder_top #(
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int PIXEL_BITS    = glzw_pkg::PIXEL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  glzw_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output glzw_pkg::out_item_t out_data
);
    import glzw_pkg::*;

    logic [3:0] mcs_reg;
    logic       wr;
    logic [3:0] wv;
    logic       restart_reg;

    logic                     dict_we, stk_we;
    logic [MAX_CODE_BITS-1:0] dict_waddr, dict_wprefix, dict_raddr, dict_rprefix;
    logic [PIXEL_BITS-1:0]    dict_wsuffix, dict_wfirst, dict_rsuffix, dict_rfirst;
    logic [MAX_CODE_BITS-1:0] stk_waddr, stk_raddr;
    logic [PIXEL_BITS-1:0]    stk_wdata, stk_rdata;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr == 2'(REG_MIN_CODE_SIZE * 4));
    assign wv = (pwdata[3:0] < 4'd2) ? 4'd2 :
                (pwdata[3:0] > 4'(PIXEL_BITS)) ? 4'(PIXEL_BITS) : pwdata[3:0];
    assign prdata = (paddr == 2'(REG_MIN_CODE_SIZE * 4)) ? {28'd0, mcs_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg     <= MIN_CODE_SIZE_RST;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= wr;
            if (wr)
                mcs_reg <= wv;
        end
    end

    glzw_ctrl #(.MAX_CODE_BITS(MAX_CODE_BITS), .PIXEL_BITS(PIXEL_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .restart(restart_reg), .min_code_size(mcs_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .dict_we(dict_we), .dict_waddr(dict_waddr), .dict_wprefix(dict_wprefix),
        .dict_wsuffix(dict_wsuffix), .dict_wfirst(dict_wfirst),
        .dict_raddr(dict_raddr), .dict_rprefix(dict_rprefix),
        .dict_rsuffix(dict_rsuffix), .dict_rfirst(dict_rfirst),
        .stk_we(stk_we), .stk_waddr(stk_waddr), .stk_wdata(stk_wdata),
        .stk_raddr(stk_raddr), .stk_rdata(stk_rdata)
    );

    glzw_tables #(.MAX_CODE_BITS(MAX_CODE_BITS), .PIXEL_BITS(PIXEL_BITS)) u_tables (
        .clk(clk),
        .dict_we(dict_we), .dict_waddr(dict_waddr), .dict_wprefix(dict_wprefix),
        .dict_wsuffix(dict_wsuffix), .dict_wfirst(dict_wfirst),
        .dict_raddr(dict_raddr), .dict_rprefix(dict_rprefix),
        .dict_rsuffix(dict_rsuffix), .dict_rfirst(dict_rfirst),
        .stk_we(stk_we), .stk_waddr(stk_waddr), .stk_wdata(stk_wdata),
        .stk_raddr(stk_raddr), .stk_rdata(stk_rdata)
    );

endmodule

FILE: rtl/glzw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_checker
// port level checks of the lzw decoder
// ----------------------------------------------------------------------------
module glzw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input glzw_pkg::out_item_t out_data
);
    import glzw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("tick without result");

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.code_done |-> out_data.index_valid)
        else $error("code_done without index");

    a_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.end_code_seen && out_data.ended_early))
        else $error("end and early end together");

endmodule

bind gif_lzw_code_decoder_top glzw_checker u_glzw_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

FILE: bench/gif_lzw_code_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_code_decoder_top_tb
// self-checking bench for the gif style lzw code decoder
// ----------------------------------------------------------------------------
// gif lzw streams are encoded and packed here, then fed one tick per transfer
// with random gaps; a tick-level decoder model predicts every result, which
// is compared against the out channel. covers clamped register values, bad
// codes, kwkwk codes, mid-stream clears and early end
// ----------------------------------------------------------------------------
module gif_lzw_code_decoder_top_tb;

    import glzw_pkg::*;

    localparam int TBL_DEPTH  = 4096;
    localparam int CYCLE_CAP  = 1000000;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_EMIT} dec_phase_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    gif_lzw_code_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // decoder model state
    int          mcs;
    logic [11:0] pfx_mem [TBL_DEPTH];
    logic [7:0]  sfx_mem [TBL_DEPTH];
    logic [7:0]  first_mem [TBL_DEPTH];
    logic [7:0]  stk_mem [TBL_DEPTH];
    int          stk_cnt;
    logic [23:0] bit_buf;
    int          bit_cnt;
    int          code_w;
    int          next_code;
    int          prev_code;
    logic [7:0]  prev_first;
    bit          have_prev;
    int          walk_ptr;
    dec_phase_t  dec_ph;
    bit          dec_done;
    bit          last_taken;
    bit          end_seen;
    bit          bad_seen;

    out_item_t   pixel_q[$];
    int          code_q[$];
    logic [7:0]  stream_q[$];
    int          pix_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  ticks;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  hold_req;
    bit  hold_used = 1'b0;
    int  hold_left = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_used)
        begin
            out_ready <= 1'b0;
            hold_left <= 300;
            hold_used <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, out_data);
            end
            else
            begin
                e = pixel_q.pop_front();
                if (out_data !== e)
                begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                end
            end
        end
    end

    function automatic void dec_restart();
        stk_cnt    = 0;
        bit_buf    = '0;
        bit_cnt    = 0;
        code_w     = mcs + 1;
        next_code  = (1 << mcs) + 2;
        prev_code  = 0;
        prev_first = '0;
        have_prev  = 1'b0;
        walk_ptr   = 0;
        dec_ph     = ST_IDLE;
        dec_done   = 1'b0;
        last_taken = 1'b0;
        end_seen   = 1'b0;
        bad_seen   = 1'b0;
    endfunction

    function automatic void stk_push(logic [7:0] v);
        if (stk_cnt < TBL_DEPTH)
        begin
            stk_mem[stk_cnt] = v;
            stk_cnt++;
        end
    endfunction

    function automatic void dict_add(int pre, logic [7:0] suf, logic [7:0] fst);
        if (next_code >= TBL_DEPTH)
            return;
        pfx_mem[next_code]   = pre[11:0];
        sfx_mem[next_code]   = suf;
        first_mem[next_code] = fst;
        next_code++;
        if (code_w < 12 && next_code == (1 << code_w))
            code_w++;
    endfunction

    function automatic void dec_code();
        int         clr;
        int         code;
        logic [7:0] fst;
        clr  = 1 << mcs;
        code = int'(bit_buf) & ((1 << code_w) - 1);
        bit_buf = bit_buf >> code_w;
        bit_cnt -= code_w;
        if (code == clr)
        begin
            code_w    = mcs + 1;
            next_code = clr + 2;
            have_prev = 1'b0;
            return;
        end
        if (code == clr + 1)
        begin
            end_seen = 1'b1;
            dec_done = 1'b1;
            return;
        end
        if (code > next_code || (code == next_code && !have_prev))
        begin
            bad_seen = 1'b1;
            return;
        end
        if (code == next_code)
        begin
            fst = prev_first;
            dict_add(prev_code, prev_first, prev_first);
            stk_push(prev_first);
            walk_ptr = prev_code;
        end
        else
        begin
            fst = (code < clr) ? code[7:0] : first_mem[code];
            if (have_prev)
                dict_add(prev_code, fst, prev_first);
            walk_ptr = code;
        end
        prev_code  = code;
        prev_first = fst;
        have_prev  = 1'b1;
        dec_ph     = ST_WALK;
    endfunction

    function automatic out_item_t dec_step(in_item_t t);
        out_item_t r;
        r = '0;
        if (dec_done)
        begin
        end
        else if (dec_ph == ST_WALK)
        begin
            if (walk_ptr < (1 << mcs))
            begin
                stk_push(walk_ptr[7:0]);
                dec_ph = ST_EMIT;
            end
            else
            begin
                stk_push(sfx_mem[walk_ptr]);
                walk_ptr = pfx_mem[walk_ptr];
            end
        end
        else if (dec_ph == ST_EMIT)
        begin
            if (stk_cnt > 0)
            begin
                stk_cnt--;
                r.pixel_index = stk_mem[stk_cnt];
                r.index_valid = 1'b1;
                if (stk_cnt == 0)
                begin
                    r.code_done = 1'b1;
                    dec_ph      = ST_IDLE;
                end
            end
            else
                dec_ph = ST_IDLE;
        end
        else if (bit_cnt >= code_w)
            dec_code();
        else if (last_taken)
            dec_done = 1'b1;
        else if (t.byte_valid)
        begin
            bit_buf = bit_buf | (24'(t.data_byte) << bit_cnt);
            bit_cnt += 8;
            r.byte_taken = 1'b1;
            if (t.final_byte)
                last_taken = 1'b1;
        end
        r.end_code_seen = end_seen;
        r.ended_early   = dec_done && !end_seen;
        r.bad_code      = bad_seen;
        return r;
    endfunction

    task automatic send_tick(input in_item_t t, output logic taken);
        out_item_t e;
        int        gap;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        e = dec_step(t);
        pixel_q.insert(pixel_q.size(), e);
        taken = e.byte_taken;
        ticks++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_min_code_size(input int v);
        int c;
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 2'(REG_MIN_CODE_SIZE * 4);
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        c = v & 15;
        if (c < 2)
            c = 2;
        if (c > PIXEL_BITS_DEF)
            c = PIXEL_BITS_DEF;
        mcs = c;
        dec_restart();
    endtask

    // gif lzw encoder: pix_q -> code_q
    task automatic encode_pixels(input bit lead_clear, input int clear_at,
                                 input bit with_end);
        int dict[int];
        int clr;
        int nxt;
        int w;
        int key;
        clr = 1 << mcs;
        nxt = clr + 2;
        code_q.delete();
        if (lead_clear)
            code_q.insert(code_q.size(), clr);
        w = pix_q[0];
        for (int i = 1; i < pix_q.size(); i++)
        begin
            if (i == clear_at)
            begin
                code_q.insert(code_q.size(), w);
                code_q.insert(code_q.size(), clr);
                dict.delete();
                nxt = clr + 2;
                w = pix_q[i];
                continue;
            end
            key = w * 256 + pix_q[i];
            if (dict.exists(key))
                w = dict[key];
            else
            begin
                code_q.insert(code_q.size(), w);
                if (nxt < TBL_DEPTH)
                begin
                    dict[key] = nxt;
                    nxt++;
                end
                w = pix_q[i];
            end
        end
        code_q.insert(code_q.size(), w);
        if (with_end)
            code_q.insert(code_q.size(), clr + 1);
    endtask

    // code_q -> stream_q, widths follow the decoder's own growth
    task automatic pack_codes();
        longint acc;
        int     n;
        int     clr;
        int     dn;
        int     w;
        bit     hp;
        clr = 1 << mcs;
        dn  = clr + 2;
        w   = mcs + 1;
        hp  = 1'b0;
        acc = 0;
        n   = 0;
        stream_q.delete();
        foreach (code_q[i])
        begin
            acc = acc | (longint'(code_q[i]) << n);
            n += w;
            while (n >= 8)
            begin
                stream_q.insert(stream_q.size(), acc[7:0]);
                acc = acc >> 8;
                n -= 8;
            end
            if (code_q[i] == clr)
            begin
                w  = mcs + 1;
                dn = clr + 2;
                hp = 1'b0;
            end
            else if (code_q[i] == clr + 1 || code_q[i] > dn || (code_q[i] == dn && !hp))
            begin
            end
            else
            begin
                if (hp && dn < TBL_DEPTH)
                begin
                    dn++;
                    if (w < 12 && dn == (1 << w))
                        w++;
                end
                hp = 1'b1;
            end
        end
        if (n > 0)
            stream_q.insert(stream_q.size(), acc[7:0]);
    endtask

    task automatic run_stream();
        in_item_t t;
        logic     taken;
        int       idx;
        idx = 0;
        while (!dec_done)
        begin
            t = in_item_t'(10'($urandom));
            if (idx < stream_q.size() && $urandom_range(9) != 0)
            begin
                t.byte_valid = 1'b1;
                t.data_byte  = stream_q[idx];
                t.final_byte = (idx == stream_q.size() - 1);
            end
            else
                t.byte_valid = 1'b0;
            send_tick(t, taken);
            if (taken)
                idx++;
        end
        repeat (3)
        begin
            send_tick(in_item_t'(10'($urandom)), taken);
        end
    endtask

    task automatic run_codes();
        pack_codes();
        run_stream();
    endtask

    task automatic test_reset_value();
        code_q = '{256, 0, 255, 1, 258, 257};
        run_codes();
    endtask

    task automatic test_register_clamp();
        write_min_code_size(1);
        pix_q = '{3, 3, 3, 3, 0, 1, 2};
        encode_pixels(1'b1, -1, 1'b1);
        run_codes();
        write_min_code_size(15);
        pix_q = '{255, 0, 255, 0, 128};
        encode_pixels(1'b1, -1, 1'b1);
        run_codes();
    endtask

    task automatic test_bad_codes();
        write_min_code_size(3);
        code_q = '{8, 10, 15, 2, 10, 3, 9};
        run_codes();
    endtask

    task automatic test_kwkwk_and_clear();
        write_min_code_size(2);
        pix_q = '{1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 0, 3};
        encode_pixels(1'b0, 7, 1'b1);
        run_codes();
    endtask

    task automatic test_early_end();
        write_min_code_size(4);
        pix_q = '{15, 0, 7, 7, 7};
        encode_pixels(1'b1, -1, 1'b0);
        run_codes();
    endtask

    task automatic test_random_streams(input int tick_goal, input bit with_hold);
        int start;
        int v;
        int n;
        int alph;
        start = ticks;
        while (ticks - start < tick_goal)
        begin
            v = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2, 8);
            write_min_code_size(v);
            if (with_hold && ticks - start > tick_goal / 3)
            begin
                hold_req  = 1'b1;
                with_hold = 1'b0;
            end
            if ($urandom_range(6) == 0)
            begin
                stream_q.delete();
                repeat ($urandom_range(2, 8))
                    stream_q.insert(stream_q.size(), 8'($urandom));
                run_stream();
                continue;
            end
            n    = $urandom_range(1, 16);
            alph = $urandom_range(1, 1 << mcs);
            pix_q.delete();
            repeat (n)
                pix_q.insert(pix_q.size(), $urandom_range(alph - 1));
            encode_pixels($urandom_range(4) != 0,
                          ($urandom_range(4) == 0) ? $urandom_range(1, n) : -1,
                          $urandom_range(6) != 0);
            pack_codes();
            if ($urandom_range(9) == 0 && stream_q.size() > 1)
                stream_q.delete(stream_q.size() - 1);
            run_stream();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        ticks        = 0;
        hold_req     = 1'b0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        mcs          = MIN_CODE_SIZE_RST;
        dec_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_value();
        test_register_clamp();
        test_bad_codes();
        test_kwkwk_and_clear();
        test_early_end();

        snd_idle_pct = 11;
        rcv_idle_pct = 52;
        test_random_streams(90, 1'b0);
        snd_idle_pct = 52;
        rcv_idle_pct = 11;
        test_random_streams(90, 1'b0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_streams(90, 1'b1);

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && pixel_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/glzw_pkg.sv
rtl/glzw_tables.sv
rtl/glzw_ctrl.sv
rtl/gif_lzw_code_decoder_top.sv
rtl/glzw_checker.sv
bench/gif_lzw_code_decoder_top_tb.sv
